>>> src/glcc_pkg.sv
// Shared types and constants for the grid line collision checker.
// Holds defaults, field widths, register indexes, reset values, action and result codes, FSM state and stepper structs.
// No dependencies.
`default_nettype none

package glcc_pkg;

    // Parameter defaults
    localparam int MAX_SIDE_DEF   = 256;
    localparam int COORD_BITS_DEF = 11;

    // Fixed field widths
    localparam int CELL_INDEX_W = 16;
    localparam int CELL_W       = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 9;
    localparam int SIZE_W       = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OCC_THRESH  = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0]        GRID_SIZE_RESET = 9'd256;
    localparam logic signed [CELL_W-1:0] THRESH_RESET    = 8'sd50;

    // Action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_CHECK = 1'b1;

    // Result codes
    typedef enum logic [1:0] {
        OUT_CLEAR      = 2'd0,
        OUT_OFF_GRID   = 2'd1,
        OUT_OCCUPIED   = 2'd2,
        OUT_WRITE_DONE = 2'd3
    } outcome_t;

    // Sequencer state
    typedef enum logic [0:0] {
        ST_IDLE = 1'b0,
        ST_WALK = 1'b1
    } state_t;

    // Controls into the line stepper
    typedef struct packed {
        logic load;
        logic advance;
    } step_ctl_t;

    // Status back from the line stepper
    typedef struct packed {
        logic in_grid;
        logic at_end;
    } step_sts_t;

endpackage

`default_nettype wire

>>> src/glcc_intf.sv
// Channel interfaces of the grid line collision checker: request, result, config.
// Each carries valid, ready and its payload. Depends on glcc_pkg.
`default_nettype none

interface glcc_req_if #(
    parameter int COORD_BITS = glcc_pkg::COORD_BITS_DEF
);
    logic                                  valid;
    logic                                  ready;
    logic                                  action;
    logic [glcc_pkg::CELL_INDEX_W-1:0]     cell_index;
    logic signed [glcc_pkg::CELL_W-1:0]    cell_value;
    logic signed [COORD_BITS-1:0]          start_col;
    logic signed [COORD_BITS-1:0]          start_row;
    logic signed [COORD_BITS-1:0]          end_col;
    logic signed [COORD_BITS-1:0]          end_row;

    modport source (
        output valid, action, cell_index, cell_value,
        output start_col, start_row, end_col, end_row,
        input  ready
    );
    modport sink (
        input  valid, action, cell_index, cell_value,
        input  start_col, start_row, end_col, end_row,
        output ready
    );
endinterface

interface glcc_rsp_if;
    logic       valid;
    logic       ready;
    logic       blocked;
    logic [1:0] outcome;

    modport source (output valid, blocked, outcome, input ready);
    modport sink (input valid, blocked, outcome, output ready);
endinterface

interface glcc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [glcc_pkg::CFG_IDX_W-1:0]    index;
    logic [glcc_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> src/glcc_grid_mem.sv
// Occupancy grid store: one write port, one read port with registered data.
// Contents are undefined until written. Depends on nothing.
`default_nettype none

module glcc_grid_mem #(
    parameter int ADDR_W = 16,
    parameter int DEPTH  = 65536
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);

    logic [7:0] mem_array [DEPTH];
    logic [7:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> src/glcc_stepper.sv
// Bresenham line stepper: holds the walk position and error term, steps one
// cell per advance, reports bounds and forms the cell address. Uses glcc_pkg.
`default_nettype none

module glcc_stepper #(
    parameter int COORD_BITS = glcc_pkg::COORD_BITS_DEF,
    parameter int SIDE_W     = 9,
    parameter int ADDR_W     = 16
) (
    input  wire logic                          clk,
    input  wire glcc_pkg::step_ctl_t           ctl,
    input  wire logic signed [COORD_BITS-1:0]  start_col,
    input  wire logic signed [COORD_BITS-1:0]  start_row,
    input  wire logic signed [COORD_BITS-1:0]  end_col,
    input  wire logic signed [COORD_BITS-1:0]  end_row,
    input  wire logic [SIDE_W-1:0]             grid_w,
    input  wire logic [SIDE_W-1:0]             grid_h,
    output glcc_pkg::step_sts_t                sts,
    output logic [ADDR_W-1:0]                  addr
);

    localparam int ERR_W = COORD_BITS + 3;
    localparam int SB    = ADDR_W / 2;
    localparam int CMP_W = ((COORD_BITS > SIDE_W) ? COORD_BITS : SIDE_W) + 1;

    logic signed [COORD_BITS-1:0] x_reg, x_next;
    logic signed [COORD_BITS-1:0] y_reg, y_next;
    logic signed [COORD_BITS-1:0] x1_reg, y1_reg;
    logic signed [ERR_W-1:0]      dx_reg, dx_next;
    logic signed [ERR_W-1:0]      dy_reg, dy_next;
    logic signed [ERR_W-1:0]      err_reg, err_next;
    logic                         sx_reg, sy_reg;

    logic signed [ERR_W-1:0]      diff_x, diff_y;
    logic signed [ERR_W:0]        e2;
    logic                         step_x, step_y;
    logic signed [CMP_W-1:0]      x_ext, y_ext, w_ext, h_ext;

    // Set-up of deltas from the segment ends
    always_comb
    begin
        diff_x  = ERR_W'(end_col) - ERR_W'(start_col);
        diff_y  = ERR_W'(end_row) - ERR_W'(start_row);
        dx_next = (diff_x < 0) ? -diff_x : diff_x;
        dy_next = (diff_y < 0) ? diff_y : -diff_y;
    end

    // One Bresenham step
    always_comb
    begin
        e2       = $signed({err_reg, 1'b0});
        step_x   = e2 >= (ERR_W+1)'(dy_reg);
        step_y   = e2 <= (ERR_W+1)'(dx_reg);
        err_next = err_reg + (step_x ? dy_reg : ERR_W'(0)) + (step_y ? dx_reg : ERR_W'(0));
        x_next   = x_reg;
        y_next   = y_reg;
        if (step_x)
        begin
            x_next = sx_reg ? x_reg + COORD_BITS'(1) : x_reg - COORD_BITS'(1);
        end
        if (step_y)
        begin
            y_next = sy_reg ? y_reg + COORD_BITS'(1) : y_reg - COORD_BITS'(1);
        end
    end

    // Walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            x_reg   <= start_col;
            y_reg   <= start_row;
            x1_reg  <= end_col;
            y1_reg  <= end_row;
            dx_reg  <= dx_next;
            dy_reg  <= dy_next;
            err_reg <= dx_next + dy_next;
            sx_reg  <= start_col < end_col;
            sy_reg  <= start_row < end_row;
        end
        else if (ctl.advance)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            err_reg <= err_next;
        end
    end

    // Bounds, end detect and row-major address
    always_comb
    begin
        x_ext = CMP_W'(x_reg);
        y_ext = CMP_W'(y_reg);
        w_ext = $signed(CMP_W'(grid_w));
        h_ext = $signed(CMP_W'(grid_h));
        sts.in_grid = (x_ext >= 0) && (x_ext < w_ext) && (y_ext >= 0) && (y_ext < h_ext);
        sts.at_end  = (x_reg == x1_reg) && (y_reg == y1_reg);
        addr = ADDR_W'(y_ext[SB-1:0]) * ADDR_W'(grid_w) + ADDR_W'(x_ext[SB-1:0]);
    end

endmodule

`default_nettype wire

>>> src/grid_line_collision_check.sv
// Timing: a write's result is registered in the cycle after the transfer; a check
// gives its result once its walk stops, at the segment end, an obstacle or the grid edge.
// Throughput: one cell per cycle, set by the stepper and the grid read port;
// a new item is taken only once the walk is over and the result slot is free.
// Reset: width and height 256, threshold 50; grid contents undefined until written.
// Top level of the grid line collision checker. Uses glcc_pkg, glcc_intf,
// glcc_stepper and glcc_grid_mem.
`default_nettype none

module grid_line_collision_check #(
    parameter int MAX_SIDE   = glcc_pkg::MAX_SIDE_DEF,
    parameter int COORD_BITS = glcc_pkg::COORD_BITS_DEF
) (
    input wire logic   clk,
    input wire logic   rst_n,
    glcc_cfg_if.sink   cfg,
    glcc_req_if.sink   req,
    glcc_rsp_if.source rsp
);

    localparam int SB          = $clog2(MAX_SIDE);
    localparam int SIDE_W      = $clog2(MAX_SIDE + 1);
    localparam int ADDR_W      = 2 * SB;
    localparam int STORE_DEPTH = MAX_SIDE * MAX_SIDE;

    glcc_pkg::state_t   state_reg, state_next;
    logic [glcc_pkg::SIZE_W-1:0]        grid_width_reg, grid_height_reg;
    logic signed [glcc_pkg::CELL_W-1:0] thresh_reg;
    logic                rsp_valid_reg, rsp_valid_next;
    glcc_pkg::outcome_t  rsp_outcome_reg, rsp_outcome_next;
    logic                pend_reg, pend_next;
    logic                pend_end_reg, pend_end_next;

    logic [SIDE_W-1:0]   grid_w, grid_h;
    logic                slot_free;
    logic                req_xfer;
    logic                wr_item;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [7:0]          rd_data;
    logic                occupied;
    logic                finish;
    glcc_pkg::outcome_t  finish_code;
    glcc_pkg::step_ctl_t step_ctl;
    glcc_pkg::step_sts_t step_sts;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= glcc_pkg::GRID_SIZE_RESET;
            grid_height_reg <= glcc_pkg::GRID_SIZE_RESET;
            thresh_reg      <= glcc_pkg::THRESH_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                glcc_pkg::REG_GRID_WIDTH:  grid_width_reg  <= cfg.data;
                glcc_pkg::REG_GRID_HEIGHT: grid_height_reg <= cfg.data;
                glcc_pkg::REG_OCC_THRESH:  thresh_reg      <= $signed(cfg.data[7:0]);
                default: ;
            endcase
        end
    end

    // Grid size saturates at the store side
    assign grid_w = (32'(grid_width_reg) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                         : SIDE_W'(grid_width_reg);
    assign grid_h = (32'(grid_height_reg) > 32'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE)
                                                          : SIDE_W'(grid_height_reg);

    // Request handshake and cell writes
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign req.ready = (state_reg == glcc_pkg::ST_IDLE) && slot_free;
    assign req_xfer  = req.valid && req.ready;
    assign wr_item   = req_xfer && (req.action == glcc_pkg::ACT_WRITE);
    assign wr_en     = wr_item && (32'(req.cell_index) < 32'(STORE_DEPTH));
    assign wr_addr   = ADDR_W'(req.cell_index);

    assign occupied = $signed(rd_data) > thresh_reg;

    // Sequencer outputs
    always_comb
    begin
        step_ctl      = '0;
        rd_en         = 1'b0;
        finish        = 1'b0;
        finish_code   = glcc_pkg::OUT_CLEAR;
        pend_next     = pend_reg;
        pend_end_next = pend_end_reg;
        case (state_reg)
            glcc_pkg::ST_IDLE:
            begin
                step_ctl.load = req.valid && slot_free && (req.action == glcc_pkg::ACT_CHECK);
                pend_next     = 1'b0;
            end
            glcc_pkg::ST_WALK:
            begin
                // previous cell's value first, then this cell's bounds
                if (pend_reg && occupied)
                begin
                    finish      = 1'b1;
                    finish_code = glcc_pkg::OUT_OCCUPIED;
                end
                else if (pend_reg && pend_end_reg)
                begin
                    finish      = 1'b1;
                    finish_code = glcc_pkg::OUT_CLEAR;
                end
                else if (!step_sts.in_grid)
                begin
                    finish      = 1'b1;
                    finish_code = glcc_pkg::OUT_OFF_GRID;
                end
                else
                begin
                    rd_en            = 1'b1;
                    step_ctl.advance = !step_sts.at_end;
                    pend_next        = 1'b1;
                    pend_end_next    = step_sts.at_end;
                end
                if (finish && slot_free)
                begin
                    pend_next = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            glcc_pkg::ST_IDLE:
            begin
                if (req_xfer && (req.action == glcc_pkg::ACT_CHECK))
                begin
                    state_next = glcc_pkg::ST_WALK;
                end
            end
            glcc_pkg::ST_WALK:
            begin
                if (finish && slot_free)
                begin
                    state_next = glcc_pkg::ST_IDLE;
                end
            end
            default: state_next = glcc_pkg::ST_IDLE;
        endcase
    end

    // Result slot
    always_comb
    begin
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_outcome_next = rsp_outcome_reg;
        if (wr_item)
        begin
            rsp_valid_next   = 1'b1;
            rsp_outcome_next = glcc_pkg::OUT_WRITE_DONE;
        end
        else if (finish && slot_free)
        begin
            rsp_valid_next   = 1'b1;
            rsp_outcome_next = finish_code;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= glcc_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            pend_reg      <= pend_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_outcome_reg <= rsp_outcome_next;
        pend_end_reg    <= pend_end_next;
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.outcome = rsp_outcome_reg;
    assign rsp.blocked = rsp_outcome_reg inside {glcc_pkg::OUT_OFF_GRID, glcc_pkg::OUT_OCCUPIED};

    // Line stepper
    glcc_stepper #(
        .COORD_BITS (COORD_BITS),
        .SIDE_W     (SIDE_W),
        .ADDR_W     (ADDR_W)
    ) u_stepper (
        .clk       (clk),
        .ctl       (step_ctl),
        .start_col (req.start_col),
        .start_row (req.start_row),
        .end_col   (req.end_col),
        .end_row   (req.end_row),
        .grid_w    (grid_w),
        .grid_h    (grid_h),
        .sts       (step_sts),
        .addr      (rd_addr)
    );

    // Occupancy store
    glcc_grid_mem #(
        .ADDR_W (ADDR_W),
        .DEPTH  (STORE_DEPTH)
    ) u_grid_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (req.cell_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

`ifndef SYNTHESIS
    a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
        wr_item |=> rsp.valid && (rsp.outcome == glcc_pkg::OUT_WRITE_DONE))
        else $error("write transfer did not give a write-done result");

    a_check_walks: assert property (@(posedge clk) disable iff (!rst_n)
        req_xfer && (req.action == glcc_pkg::ACT_CHECK) |=> state_reg == glcc_pkg::ST_WALK)
        else $error("check transfer did not start a walk");

    a_read_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> step_sts.in_grid && (state_reg == glcc_pkg::ST_WALK))
        else $error("grid read issued outside the grid or outside a walk");

    a_finish_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == glcc_pkg::ST_WALK) && finish && slot_free |=> rsp.valid && !pend_reg)
        else $error("finished walk left no result");
`endif

endmodule

`default_nettype wire

>>> verif/grid_line_collision_check_tb.sv
// Self-checking bench for grid_line_collision_check: cell writes and line checks
// against an in-bench occupancy grid and Bresenham walk, under random flow control.
// Depends on glcc_pkg, glcc_intf and the RTL of grid_line_collision_check.

module grid_line_collision_check_tb;

    import glcc_pkg::*;

    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int RUN_LIMIT    = 4_000_000;
    localparam int DRAIN_CYCLES = 300;
    localparam int STALL_CYCLES = 400;
    localparam int PHASE_ITEMS  = 115;
    localparam int N_SETTINGS   = 12;

    // One request as the sender offers it
    typedef struct {
        logic                          action;
        logic [CELL_INDEX_W-1:0]       cell_index;
        logic signed [CELL_W-1:0]      cell_value;
        logic signed [COORD_BITS-1:0]  start_col;
        logic signed [COORD_BITS-1:0]  start_row;
        logic signed [COORD_BITS-1:0]  end_col;
        logic signed [COORD_BITS-1:0]  end_row;
    } grid_req_t;

    // One result as the block should return it
    typedef struct {
        logic     blocked;
        outcome_t outcome;
    } line_verdict_t;

    // Shadow grid, shadow registers and the verdicts still owed by the block
    class line_check_scoreboard;
        byte           cells [0:65535];
        bit            written [0:65535];
        int            width_reg;
        int            height_reg;
        int            thresh_reg;
        line_verdict_t verdicts_due [$];
        int            errors;

        function new();
            width_reg  = int'(GRID_SIZE_RESET);
            height_reg = int'(GRID_SIZE_RESET);
            thresh_reg = int'(THRESH_RESET);
            errors     = 0;
        endfunction

        function int side(int s);
            return (s > MAX_SIDE_DEF) ? MAX_SIDE_DEF : s;
        endfunction

        function void complain(string msg);
            errors++;
            if (errors <= 10)
                $display("MISMATCH: %s", msg);
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GRID_WIDTH:  width_reg  = int'(data);
                REG_GRID_HEIGHT: height_reg = int'(data);
                REG_OCC_THRESH:  thresh_reg = int'($signed(data[CELL_W-1:0]));
                default: ;
            endcase
        endfunction

        // Bresenham walk; hole is set to the first never-written cell the walk
        // would read, or -1 when every cell read has been written
        function outcome_t walk_segment(grid_req_t r, output int hole);
            int w, h, x0, y0, x1, y1, dx, dy, sx, sy, err, e2, x, y, idx;
            hole = -1;
            w  = side(width_reg);
            h  = side(height_reg);
            x0 = int'(r.start_col);
            y0 = int'(r.start_row);
            x1 = int'(r.end_col);
            y1 = int'(r.end_row);
            dx = (x1 > x0) ? x1 - x0 : x0 - x1;
            dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
            sx = (x0 < x1) ? 1 : -1;
            sy = (y0 < y1) ? 1 : -1;
            err = dx + dy;
            x = x0;
            y = y0;
            // a line never spans more than 2048 cells
            for (int n = 0; n < 4096; n++)
            begin
                if (x < 0 || x >= w || y < 0 || y >= h)
                    return OUT_OFF_GRID;
                idx = y * w + x;
                if (!written[idx])
                begin
                    hole = idx;
                    return OUT_CLEAR;
                end
                if (int'(cells[idx]) > thresh_reg)
                    return OUT_OCCUPIED;
                if (x == x1 && y == y1)
                    return OUT_CLEAR;
                e2 = 2 * err;
                if (e2 >= dy)
                begin
                    err += dy;
                    x   += sx;
                end
                if (e2 <= dx)
                begin
                    err += dx;
                    y   += sy;
                end
            end
            return OUT_CLEAR;
        endfunction

        // Request transfer: update the grid or walk the line, queue the verdict
        function void note_input(grid_req_t r);
            line_verdict_t v;
            int hole;
            if (r.action == ACT_WRITE)
            begin
                cells[r.cell_index]   = r.cell_value;
                written[r.cell_index] = 1'b1;
                v.outcome = OUT_WRITE_DONE;
            end
            else
                v.outcome = walk_segment(r, hole);
            v.blocked = (v.outcome == OUT_OFF_GRID || v.outcome == OUT_OCCUPIED);
            verdicts_due.insert(verdicts_due.size(), v);
        endfunction

        // Result transfer: compare with the oldest verdict owed
        function void check_result(logic blocked, logic [1:0] outcome);
            line_verdict_t v;
            if (verdicts_due.size() == 0)
            begin
                complain($sformatf("result with none pending: blocked %0b outcome %0d",
                                   blocked, outcome));
                return;
            end
            v = verdicts_due.pop_front();
            if (blocked !== v.blocked || outcome !== v.outcome)
                complain($sformatf("blocked exp %0b got %0b, outcome exp %0d got %0d",
                                   v.blocked, blocked, v.outcome, outcome));
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic hold_req;
    int   hold_left;
    int   cycles;
    int   send_idle;
    int   recv_idle;
    int   items_sent;
    int   win_x;
    int   win_y;

    line_check_scoreboard sb;

    glcc_req_if #(.COORD_BITS(COORD_BITS)) req_if ();
    glcc_rsp_if rsp_if ();
    glcc_cfg_if cfg_if ();

    grid_line_collision_check #(
        .MAX_SIDE   (MAX_SIDE_DEF),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Receiver: random back-pressure, or a long hold-off when asked
    always @(posedge clk)
    begin
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else if (hold_req)
        begin
            hold_left = STALL_CYCLES;
            hold_req     <= 1'b0;
            rsp_if.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(99, 0) >= recv_idle);
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            sb.check_result(rsp_if.blocked, rsp_if.outcome);
    end

    // Offer one request, with random idle cycles in front; valid stays high after
    task automatic drive_item(grid_req_t r);
        while ($urandom_range(99, 0) < send_idle)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid      <= 1'b1;
        req_if.action     <= r.action;
        req_if.cell_index <= r.cell_index;
        req_if.cell_value <= r.cell_value;
        req_if.start_col  <= r.start_col;
        req_if.start_row  <= r.start_row;
        req_if.end_col    <= r.end_col;
        req_if.end_row    <= r.end_row;
        @(posedge clk);
        while (req_if.ready !== 1'b1)
            @(posedge clk);
        sb.note_input(r);
        items_sent++;
    endtask

    // Cell write; segment fields carry junk
    task automatic send_write(int idx, int val);
        grid_req_t r;
        r.action     = ACT_WRITE;
        r.cell_index = idx[CELL_INDEX_W-1:0];
        r.cell_value = val[CELL_W-1:0];
        r.start_col  = COORD_BITS'($urandom);
        r.start_row  = COORD_BITS'($urandom);
        r.end_col    = COORD_BITS'($urandom);
        r.end_row    = COORD_BITS'($urandom);
        drive_item(r);
    endtask

    // Fill value: mostly free space at or below the current threshold, some obstacles
    function automatic int pick_fill();
        int t;
        t = sb.thresh_reg;
        if (t >= 127 || $urandom_range(99, 0) < 85)
            return int'($urandom_range(t + 128, 0)) - 128;
        return int'($urandom_range(126 - t, 0)) + t + 1;
    endfunction

    function automatic int rand_coord();
        logic signed [COORD_BITS-1:0] c;
        c = COORD_BITS'($urandom);
        return int'(c);
    endfunction

    // Line check; first writes every cell the walk would read that is still blank
    task automatic check_segment(int sc, int sr, int ec, int er);
        grid_req_t r;
        int hole;
        outcome_t o;
        r.action     = ACT_CHECK;
        r.cell_index = CELL_INDEX_W'($urandom);
        r.cell_value = CELL_W'($urandom);
        r.start_col  = sc[COORD_BITS-1:0];
        r.start_row  = sr[COORD_BITS-1:0];
        r.end_col    = ec[COORD_BITS-1:0];
        r.end_row    = er[COORD_BITS-1:0];
        o = sb.walk_segment(r, hole);
        while (hole >= 0)
        begin
            send_write(hole, pick_fill());
            o = sb.walk_segment(r, hole);
        end
        drive_item(r);
    endtask

    // One random request shaped by the current grid size
    task automatic random_op();
        int w, h, r, len, x0, y0;
        w = sb.side(sb.width_reg);
        h = sb.side(sb.height_reg);
        r = $urandom_range(99, 0);
        if (r < 10)
            send_write($urandom_range(65535, 0), $urandom_range(255, 0));
        else if (r < 18 && w * h > 0)
            send_write($urandom_range(w * h - 1, 0), pick_fill());
        else if (r < 32)
            check_segment(rand_coord(), rand_coord(), rand_coord(), rand_coord());
        else if (r < 42 && w > 0 && h > 0 && w * h <= 4096)
            check_segment($urandom_range(w - 1, 0), $urandom_range(h - 1, 0),
                          $urandom_range(w - 1, 0), $urandom_range(h - 1, 0));
        else
        begin
            // short segment from inside a window, so cells get reused
            len = ($urandom_range(9, 0) == 0) ? 40 : 10;
            x0 = (w > 0) ? win_x + $urandom_range(((w < 24) ? w : 24) - 1, 0)
                         : $urandom_range(3, 0);
            y0 = (h > 0) ? win_y + $urandom_range(((h < 24) ? h : 24) - 1, 0)
                         : $urandom_range(3, 0);
            check_segment(x0, y0, x0 + int'($urandom_range(2 * len, 0)) - len,
                          y0 + int'($urandom_range(2 * len, 0)) - len);
        end
    endtask

    // Register writes back to back, valid held high between transfers
    task automatic write_registers(int w, int h, int t);
        logic [CFG_IDX_W-1:0] idx [3];
        int vals [3];
        idx  = '{REG_GRID_WIDTH, REG_GRID_HEIGHT, REG_OCC_THRESH};
        vals = '{w, h, t};
        for (int i = 0; i < 3; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= idx[i];
            cfg_if.data  <= vals[i][CFG_DATA_W-1:0];
            @(posedge clk);
            while (cfg_if.ready !== 1'b1)
                @(posedge clk);
            sb.set_register(idx[i], vals[i][CFG_DATA_W-1:0]);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Stop offering and wait for every owed result
    task automatic drain(int settle);
        req_if.valid <= 1'b0;
        while (sb.verdicts_due.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Main sequence
    initial
    begin
        int cfg_w [N_SETTINGS];
        int cfg_h [N_SETTINGS];
        int cfg_t [N_SETTINGS];
        int phase_end;
        int w, h;

        // settings: small, one cell, full, zero width; saturated, tall, wide,
        // zero height; then mixed with the long stall on the first
        cfg_w = '{16, 1, 256, 0, 511, 5, 40, 12, 32, 257, 2, 64};
        cfg_h = '{16, 1, 256, 12, 300, 40, 3, 0, 24, 256, 255, 64};
        cfg_t = '{50, -128, 127, 0, -1, 100, -128, 10, 60, -50, 127, 50};

        sb = new();
        cycles     = 0;
        items_sent = 0;
        hold_left  = 0;
        hold_req   = 1'b0;
        win_x      = 0;
        win_y      = 0;
        rst_n      = 1'b0;
        req_if.valid      = 1'b0;
        req_if.action     = ACT_WRITE;
        req_if.cell_index = '0;
        req_if.cell_value = '0;
        req_if.start_col  = '0;
        req_if.start_row  = '0;
        req_if.end_col    = '0;
        req_if.end_row    = '0;
        rsp_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = REG_GRID_WIDTH;
        cfg_if.data       = '0;
        send_idle = 36;
        recv_idle = 87;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the reset settings
        send_write(0, 127);
        send_write(65535, -128);
        send_write(1, 50);
        send_write(2, 51);
        check_segment(0, 0, 0, 0);            // top value is an obstacle
        check_segment(1, 0, 1, 0);            // value equal to threshold is free
        check_segment(2, 0, 2, 0);            // one above threshold
        check_segment(255, 255, 255, 255);    // last cell, lowest value
        check_segment(-1, 0, 5, 0);           // starts left of the grid
        check_segment(0, -1, 0, 3);           // starts above the grid
        check_segment(256, 0, 0, 0);          // starts right of the grid
        check_segment(0, 256, 0, 0);          // starts below the grid
        check_segment(-1024, -1024, 1023, 1023);
        check_segment(1023, 1023, -1024, -1024);
        check_segment(4, 0, 1, 0);            // walks left into an obstacle
        check_segment(253, 10, 258, 10);      // leaves the grid on the right
        check_segment(10, 20, 11, 23);        // steep
        check_segment(30, 30, 27, 28);        // shallow, both steps negative
        drain(4);

        // Random part, one block of items per setting
        for (int k = 0; k < N_SETTINGS; k++)
        begin
            send_idle = (k < 4) ? 36 : (k < 8) ? 87 : 0;
            recv_idle = (k < 4) ? 87 : (k < 8) ? 36 : 0;
            write_registers(cfg_w[k], cfg_h[k], cfg_t[k]);
            w = sb.side(sb.width_reg);
            h = sb.side(sb.height_reg);
            win_x = (w > 24) ? $urandom_range(w - 24, 0) : 0;
            win_y = (h > 24) ? $urandom_range(h - 24, 0) : 0;
            if (k == 8)
                hold_req <= 1'b1;
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
                random_op();
            drain(4);
        end

        // Let anything stray surface
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.verdicts_due.size() != 0)
            sb.complain($sformatf("%0d results never arrived", sb.verdicts_due.size()));

        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
